>>> hw/rtl/mlpsig_pkg.sv
// Shared types, constants and saturation helper for the sigmoid perceptron trainer.
`timescale 1ns / 1ps
`default_nettype none

package mlpsig_pkg;

   localparam logic signed [31:0] Q_ONE    = 32'sd65536;
   localparam logic [16:0]        LR_RESET = 17'd6554;

   typedef enum logic [1:0] {
      CMD_TRAIN   = 2'd0,
      CMD_PREDICT = 2'd1,
      CMD_WRITE   = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FH,
      ST_FO,
      ST_DO,
      ST_HD,
      ST_VU,
      ST_WU,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] feature_open;
      logic signed [31:0] feature_high;
      logic signed [31:0] feature_low;
      logic signed [31:0] feature_close;
      logic [6:0]         weight_index;
      logic signed [31:0] weight_value;
   } req_type;

   typedef struct packed {
      logic [16:0] score_range;
      logic [16:0] score_direction;
      logic [16:0] score_future;
      logic        is_write_ack;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
      if (v > 56'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -56'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mlpsig_sigmoid.sv
// Sigmoid lookup table over [-8, 8) with clamped index.
`timescale 1ns / 1ps
`default_nettype none

module mlpsig_sigmoid import mlpsig_pkg::*; #(
   parameter int DEPTH = 256
) (
   input  logic signed [31:0] x,
   output logic [16:0]        y
);

   localparam int IW = $clog2(DEPTH);
   localparam longint ONE30 = 64'sd1073741824;

   logic [16:0]        rom [DEPTH];
   logic signed [33:0] xx;
   logic [46:0]        scaled;
   logic [46:0]        shifted;
   logic [IW-1:0]      idx;

   for (genvar n = 0; n < DEPTH; n++) begin : g_rom
      localparam longint NUM = longint'(2 * n + 1) * 64'sd524288;
      localparam longint C   = -64'sd524288 + NUM / DEPTH;
      localparam longint T   = (C < 0) ? -C : C;
      localparam longint U   = T * 64'sd1024;
      localparam longint T1  = ((ONE30 * U) >>> 30) / 1;
      localparam longint T2  = ((T1 * U) >>> 30) / 2;
      localparam longint T3  = ((T2 * U) >>> 30) / 3;
      localparam longint T4  = ((T3 * U) >>> 30) / 4;
      localparam longint T5  = ((T4 * U) >>> 30) / 5;
      localparam longint T6  = ((T5 * U) >>> 30) / 6;
      localparam longint T7  = ((T6 * U) >>> 30) / 7;
      localparam longint T8  = ((T7 * U) >>> 30) / 8;
      localparam longint T9  = ((T8 * U) >>> 30) / 9;
      localparam longint T10 = ((T9 * U) >>> 30) / 10;
      localparam longint T11 = ((T10 * U) >>> 30) / 11;
      localparam longint T12 = ((T11 * U) >>> 30) / 12;
      localparam longint SUM = ONE30 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9
                               + T10 - T11 + T12;
      localparam longint E0  = (SUM < 0) ? 64'sd0 : SUM;
      localparam longint E1  = (E0 * E0 + 64'sd536870912) >>> 30;
      localparam longint E2  = (E1 * E1 + 64'sd536870912) >>> 30;
      localparam longint E3  = (E2 * E2 + 64'sd536870912) >>> 30;
      localparam longint E4  = (E3 * E3 + 64'sd536870912) >>> 30;
      localparam longint D   = ONE30 + E4;
      localparam longint S   = ((64'sd1 <<< 46) + D / 2) / D;
      localparam longint V   = (C < 0) ? (64'sd65536 - S) : S;
      assign rom[n] = 17'(V);
   end

   always_comb begin
      xx      = 34'(x) + 34'sd524288;
      scaled  = {14'b0, xx[32:0]} * 47'(DEPTH);
      shifted = scaled >> 20;
      if (xx[33]) begin
         idx = '0;
      end else if (shifted >= 47'(DEPTH)) begin
         idx = IW'(DEPTH - 1);
      end else begin
         idx = shifted[IW-1:0];
      end
   end

   assign y = rom[idx];

endmodule

`default_nettype wire

>>> hw/rtl/mlp_sigmoid_online_backprop_top.sv
// Top level: sequencer, weight store and shared multiply unit of the perceptron trainer.
// Every product goes through the single 32x32 multiplier and one weight store read port.
// A weight write or an unused command answers on the next cycle with no busy time.
// Reset clears the weights, the sequencer and sets the learning rate to 0.1.
`timescale 1ns / 1ps
`default_nettype none

module mlp_sigmoid_online_backprop_top import mlpsig_pkg::*; #(
   parameter int HIDDEN_UNITS        = 10,
   parameter int SIGMOID_TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);

   localparam int NW    = 7 * HIDDEN_UNITS;
   localparam int AW    = $clog2(NW);
   localparam int VBASE = 4 * HIDDEN_UNITS;
   localparam int JW    = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;

   state_type          state_ff, state_in;
   logic [2:0]         ph_ff, ph_in;
   logic [JW-1:0]      j_ff, j_in;
   logic [1:0]         k_ff, k_in;
   logic signed [55:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] feat_ff [4];
   logic signed [31:0] feat_in [4];
   logic [1:0]         cmd_ff, cmd_in;
   logic [16:0]        h_ff [HIDDEN_UNITS];
   logic [16:0]        h_in [HIDDEN_UNITS];
   logic signed [31:0] g_ff [HIDDEN_UNITS];
   logic signed [31:0] g_in [HIDDEN_UNITS];
   logic signed [31:0] d_ff [3];
   logic signed [31:0] d_in [3];
   logic [16:0]        o_ff [3];
   logic [16:0]        o_in [3];
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [16:0]        lr_ff;

   logic signed [31:0] wmem [NW];
   logic [NW-1:0]      wvalid_ff;
   logic signed [31:0] rdata_ff;

   logic               mul_en;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_res;
   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic signed [31:0] wr_data;

   logic signed [55:0] prod_shift;
   logic signed [31:0] qs, acc_sat, h_cur, o_cur, d_cur, g_cur, feat_cur, lr32;
   logic signed [31:0] tgt, err, msum;
   logic [AW-1:0]      addr_wi, addr_v;
   logic               j_last;
   logic [16:0]        sig_y;

   mlpsig_sigmoid #(
      .DEPTH (SIGMOID_TABLE_DEPTH)
   ) u_sigmoid (
      .x (acc_sat),
      .y (sig_y)
   );

   always_comb begin
      prod_shift = 56'(prod_ff >>> 16);
      qs         = sat32(prod_shift);
      acc_sat    = sat32(acc_ff);
      h_cur      = 32'(h_ff[j_ff]);
      g_cur      = g_ff[j_ff];
      o_cur      = 32'(o_ff[k_ff]);
      d_cur      = d_ff[k_ff];
      feat_cur   = feat_ff[k_ff];
      lr32       = 32'(lr_ff);
      addr_wi    = AW'(int'(k_ff) * HIDDEN_UNITS + int'(j_ff));
      addr_v     = AW'(VBASE + int'(j_ff) * 3 + int'(k_ff));
      j_last     = (j_ff == JW'(HIDDEN_UNITS - 1));
      msum       = sat32(56'(rdata_ff) + 56'(qs));
      case (k_ff)
         2'd0:    tgt = sat32(56'(feat_ff[1]) - 56'(feat_ff[2]));
         2'd1:    tgt = (feat_ff[0] > feat_ff[3]) ? Q_ONE : 32'sd0;
         default: tgt = 32'sd0;
      endcase
      err = sat32(56'(tgt) - 56'(o_cur));
   end

   assign mul_res = mul_a * mul_b;
   assign prod_in = mul_en ? mul_res : prod_ff;

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      feat_in      = feat_ff;
      cmd_in       = cmd_ff;
      h_in         = h_ff;
      g_in         = g_ff;
      d_in         = d_ff;
      o_in         = o_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      rd_en        = 1'b0;
      rd_addr      = addr_wi;
      wr_en        = 1'b0;
      wr_addr      = addr_wi;
      wr_data      = msum;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               feat_in[0] = req_data.feature_open;
               feat_in[1] = req_data.feature_high;
               feat_in[2] = req_data.feature_low;
               feat_in[3] = req_data.feature_close;
               cmd_in     = req_data.cmd;
               case (req_data.cmd)
                  CMD_WRITE: begin
                     if (int'(req_data.weight_index) < NW) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(req_data.weight_index);
                        wr_data = req_data.weight_value;
                     end
                     rsp_valid_in        = 1'b1;
                     rsp_in              = '0;
                     rsp_in.is_write_ack = 1'b1;
                  end
                  CMD_NOP: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end
                  default: begin
                     state_in = ST_FH;
                     ph_in    = 3'd0;
                     j_in     = '0;
                     k_in     = 2'd0;
                     acc_in   = '0;
                  end
               endcase
            end
         end
         ST_FH: begin
            case (ph_ff)
               3'd0: begin
                  rd_en   = 1'b1;
                  rd_addr = addr_wi;
                  ph_in   = 3'd1;
               end
               3'd1: begin
                  mul_en = 1'b1;
                  mul_a  = feat_cur;
                  mul_b  = rdata_ff;
                  ph_in  = 3'd2;
               end
               3'd2: begin
                  acc_in = acc_ff + prod_shift;
                  if (k_ff == 2'd3) begin
                     ph_in = 3'd3;
                  end else begin
                     k_in  = k_ff + 2'd1;
                     ph_in = 3'd0;
                  end
               end
               default: begin
                  h_in[j_ff] = sig_y;
                  acc_in     = '0;
                  k_in       = 2'd0;
                  ph_in      = 3'd0;
                  if (j_last) begin
                     j_in     = '0;
                     state_in = ST_FO;
                  end else begin
                     j_in = j_ff + JW'(1);
                  end
               end
            endcase
         end
         ST_FO: begin
            case (ph_ff)
               3'd0: begin
                  rd_en   = 1'b1;
                  rd_addr = addr_v;
                  ph_in   = 3'd1;
               end
               3'd1: begin
                  mul_en = 1'b1;
                  mul_a  = h_cur;
                  mul_b  = rdata_ff;
                  ph_in  = 3'd2;
               end
               3'd2: begin
                  acc_in = acc_ff + prod_shift;
                  if (j_last) begin
                     ph_in = 3'd3;
                  end else begin
                     j_in  = j_ff + JW'(1);
                     ph_in = 3'd0;
                  end
               end
               default: begin
                  o_in[k_ff] = sig_y;
                  acc_in     = '0;
                  j_in       = '0;
                  ph_in      = 3'd0;
                  if (k_ff == 2'd2) begin
                     k_in     = 2'd0;
                     state_in = (cmd_ff == CMD_PREDICT) ? ST_DONE : ST_DO;
                  end else begin
                     k_in = k_ff + 2'd1;
                  end
               end
            endcase
         end
         ST_DO: begin
            case (ph_ff)
               3'd0: begin
                  mul_en = 1'b1;
                  mul_a  = err;
                  mul_b  = o_cur;
                  ph_in  = 3'd1;
               end
               3'd1: begin
                  mul_en = 1'b1;
                  mul_a  = qs;
                  mul_b  = Q_ONE - o_cur;
                  ph_in  = 3'd2;
               end
               default: begin
                  d_in[k_ff] = qs;
                  ph_in      = 3'd0;
                  if (k_ff == 2'd2) begin
                     k_in     = 2'd0;
                     j_in     = '0;
                     state_in = ST_HD;
                  end else begin
                     k_in = k_ff + 2'd1;
                  end
               end
            endcase
         end
         ST_HD: begin
            case (ph_ff)
               3'd0: begin
                  rd_en   = 1'b1;
                  rd_addr = addr_v;
                  ph_in   = 3'd1;
               end
               3'd1: begin
                  mul_en = 1'b1;
                  mul_a  = d_cur;
                  mul_b  = rdata_ff;
                  ph_in  = 3'd2;
               end
               3'd2: begin
                  acc_in = acc_ff + prod_shift;
                  if (k_ff == 2'd2) begin
                     ph_in = 3'd3;
                  end else begin
                     k_in  = k_ff + 2'd1;
                     ph_in = 3'd0;
                  end
               end
               3'd3: begin
                  mul_en = 1'b1;
                  mul_a  = acc_sat;
                  mul_b  = h_cur;
                  ph_in  = 3'd4;
               end
               3'd4: begin
                  mul_en = 1'b1;
                  mul_a  = qs;
                  mul_b  = Q_ONE - h_cur;
                  ph_in  = 3'd5;
               end
               default: begin
                  g_in[j_ff] = qs;
                  acc_in     = '0;
                  k_in       = 2'd0;
                  ph_in      = 3'd0;
                  if (j_last) begin
                     j_in     = '0;
                     state_in = ST_VU;
                  end else begin
                     j_in = j_ff + JW'(1);
                  end
               end
            endcase
         end
         ST_VU: begin
            case (ph_ff)
               3'd0: begin
                  rd_en   = 1'b1;
                  rd_addr = addr_v;
                  mul_en  = 1'b1;
                  mul_a   = lr32;
                  mul_b   = d_cur;
                  ph_in   = 3'd1;
               end
               3'd1: begin
                  mul_en = 1'b1;
                  mul_a  = qs;
                  mul_b  = h_cur;
                  ph_in  = 3'd2;
               end
               default: begin
                  wr_en   = 1'b1;
                  wr_addr = addr_v;
                  wr_data = msum;
                  ph_in   = 3'd0;
                  if (k_ff == 2'd2) begin
                     k_in = 2'd0;
                     if (j_last) begin
                        j_in     = '0;
                        state_in = ST_WU;
                     end else begin
                        j_in = j_ff + JW'(1);
                     end
                  end else begin
                     k_in = k_ff + 2'd1;
                  end
               end
            endcase
         end
         ST_WU: begin
            case (ph_ff)
               3'd0: begin
                  rd_en   = 1'b1;
                  rd_addr = addr_wi;
                  mul_en  = 1'b1;
                  mul_a   = lr32;
                  mul_b   = g_cur;
                  ph_in   = 3'd1;
               end
               3'd1: begin
                  mul_en = 1'b1;
                  mul_a  = qs;
                  mul_b  = feat_cur;
                  ph_in  = 3'd2;
               end
               default: begin
                  wr_en   = 1'b1;
                  wr_addr = addr_wi;
                  wr_data = msum;
                  ph_in   = 3'd0;
                  if (j_last) begin
                     j_in = '0;
                     if (k_ff == 2'd3) begin
                        k_in     = 2'd0;
                        state_in = ST_DONE;
                     end else begin
                        k_in = k_ff + 2'd1;
                     end
                  end else begin
                     j_in = j_ff + JW'(1);
                  end
               end
            endcase
         end
         ST_DONE: begin
            rsp_valid_in           = 1'b1;
            rsp_in.score_range     = o_ff[0];
            rsp_in.score_direction = o_ff[1];
            rsp_in.score_future    = o_ff[2];
            rsp_in.is_write_ack    = 1'b0;
            state_in               = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= 3'd0;
         j_ff         <= '0;
         k_ff         <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      feat_ff <= feat_in;
      cmd_ff  <= cmd_in;
      h_ff    <= h_in;
      g_ff    <= g_in;
      d_ff    <= d_in;
      o_ff    <= o_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= LR_RESET;
      end else if (csr_we) begin
         lr_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wvalid_ff <= '0;
      end else if (wr_en) begin
         wvalid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wmem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= wvalid_ff[rd_addr] ? wmem[rd_addr] : 32'sd0;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while the sequencer is busy");

   a_run_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.cmd == CMD_TRAIN || req_data.cmd == CMD_PREDICT))
      |=> busy)
      else $error("accepted network command did not start the sequencer");

   a_hidden_index: assert property (@(posedge clock) disable iff (reset)
      int'(j_ff) < HIDDEN_UNITS)
      else $error("hidden unit counter out of range");

   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_write_ack) |->
      (rsp_data.score_range == 17'd0 && rsp_data.score_direction == 17'd0 &&
       rsp_data.score_future == 17'd0))
      else $error("write acknowledge carries nonzero scores");

endmodule

`default_nettype wire
